[hdl/dtpu_pkg.sv]
package dtpu_pkg;

  localparam logic [32:0] DosMinSecs = 33'd315532800;
  localparam logic [32:0] DosMaxSecs = 33'd4354819198;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin = 6'd60;

  // Days since 1970-01-01 of 1976-03-01 and of 2100-03-01
  localparam logic [15:0] MarchBase = 16'd2251;
  localparam logic [15:0] Day2100Mar = 16'd47541;
  localparam logic [15:0] Idx2100Mar = 16'd45291;

  // Reciprocals for constant division
  localparam logic [27:0] RecipDay128 = 28'd203613265;  // 2^37 / 675
  localparam logic [15:0] Recip1460 = 16'd45965;         // 2^26 / 1460
  localparam logic [16:0] Recip365 = 17'd91930;          // 2^25 / 365
  localparam logic [16:0] RecipHour = 17'd74566;         // 2^28 / 3600
  localparam logic [12:0] RecipMin = 13'd4370;           // 2^18 / 60
  localparam logic [12:0] Recip153 = 13'd6854;           // 2^20 / 153
  localparam logic [13:0] Recip5 = 14'd13108;            // 2^16 / 5

  localparam int unsigned LaneDepth = 7;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2: r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // (153 * mp + 2) / 5 for mp in 0..11
  function automatic logic [8:0] month_base(input logic [3:0] mp);
    logic [10:0] num;
    logic [24:0] prod;
    num = 11'(mp) * 11'd153 + 11'd2;
    prod = 25'(num) * 25'(Recip5);
    return prod[24:16];
  endfunction

endpackage

[hdl/dtpu_in_if.sv]
interface dtpu_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] epoch_seconds;
  logic [15:0] packed_date;
  logic [15:0] packed_time;

  modport source (output valid, action, epoch_seconds, packed_date, packed_time, input ready);
  modport sink (input valid, action, epoch_seconds, packed_date, packed_time, output ready);
endinterface

[hdl/dtpu_out_if.sv]
interface dtpu_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] packed_date_out;
  logic [15:0] packed_time_out;
  logic [32:0] epoch_seconds_out;

  modport source (output valid, ok, packed_date_out, packed_time_out, epoch_seconds_out,
                  input ready);
  modport sink (input valid, ok, packed_date_out, packed_time_out, epoch_seconds_out,
                output ready);
endinterface

[hdl/dtpu_pack_lane.sv]
module dtpu_pack_lane import dtpu_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] epoch_i,
  output logic [15:0] date_o,
  output logic [15:0] time_o
);

  logic [32:0] t1_d, t1_q, t2_q;
  logic [53:0] qprod;
  logic [15:0] q2_q;
  logic [32:0] qsec;
  logic [32:0] sod_full;
  logic [15:0] a3_d, a3_q, a4_q, a5_q;
  logic [16:0] sod3_q, sod4_q;
  logic [31:0] cprod;
  logic [33:0] hprod;
  logic [5:0]  c4_q;
  logic [4:0]  h4_q, h5_q, h6_q, h7_q;
  logic [15:0] yn;
  logic [32:0] yprod;
  logic [7:0]  yoe5_q, yoe6_q, yoe7_q;
  logic [11:0] rest5_q, rest6_q;
  logic [16:0] hsec;
  logic [15:0] ydays;
  logic [15:0] doy_full;
  logic [8:0]  doy6_q, doy7_q;
  logic [24:0] mprod;
  logic [5:0]  mi6_q, mi7_q;
  logic [10:0] mpnum;
  logic [23:0] mpprod;
  logic [3:0]  mp7_q;
  logic [11:0] msec;
  logic [11:0] sec_full;
  logic [4:0]  s7_q;
  logic [8:0]  dd;
  logic [3:0]  mm;
  logic [7:0]  yr;

  always_comb begin
    if (epoch_i < 64'(DosMinSecs)) begin
      t1_d = DosMinSecs;
    end else if (epoch_i > 64'(DosMaxSecs)) begin
      t1_d = DosMaxSecs;
    end else begin
      t1_d = epoch_i[32:0];
    end
  end

  assign qprod = 54'(t1_q[32:7]) * 54'(RecipDay128);
  assign qsec = 33'(q2_q) * 33'(SecsPerDay);
  assign sod_full = t2_q - qsec;
  assign a3_d = q2_q - MarchBase + 16'(q2_q >= Day2100Mar);
  assign cprod = 32'(a3_q) * 32'(Recip1460);
  assign hprod = 34'(sod3_q) * 34'(RecipHour);
  assign yn = a4_q - 16'(c4_q);
  assign yprod = 33'(yn) * 33'(Recip365);
  assign hsec = 17'(h4_q) * 17'(SecsPerHour);
  assign ydays = 16'(yoe5_q) * 16'd365 + 16'(yoe5_q[7:2]);
  assign doy_full = a5_q - ydays;
  assign mprod = 25'(rest5_q) * 25'(RecipMin);
  assign mpnum = 11'(doy6_q) * 11'd5 + 11'd2;
  assign mpprod = 24'(mpnum) * 24'(Recip153);
  assign msec = 12'(mi6_q) * 12'(SecsPerMin);
  assign sec_full = rest6_q - msec;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= t1_d;
      t2_q <= t1_q;
      q2_q <= qprod[52:37];
      a3_q <= a3_d;
      sod3_q <= sod_full[16:0];
      a4_q <= a3_q;
      c4_q <= cprod[31:26];
      h4_q <= hprod[32:28];
      sod4_q <= sod3_q;
      a5_q <= a4_q;
      yoe5_q <= yprod[32:25];
      h5_q <= h4_q;
      rest5_q <= 12'(sod4_q - hsec);
      doy6_q <= doy_full[8:0];
      yoe6_q <= yoe5_q;
      h6_q <= h5_q;
      mi6_q <= mprod[23:18];
      rest6_q <= rest5_q;
      doy7_q <= doy6_q;
      mp7_q <= mpprod[23:20];
      yoe7_q <= yoe6_q;
      h7_q <= h6_q;
      mi7_q <= mi6_q;
      s7_q <= sec_full[5:1];
    end
  end

  always_comb begin
    dd = doy7_q - month_base(mp7_q) + 9'd1;
    mm = (mp7_q < 4'd10) ? mp7_q + 4'd3 : mp7_q - 4'd9;
    yr = yoe7_q + 8'(mm <= 4'd2) - 8'd4;
  end

  assign date_o = {yr[6:0], mm, dd[4:0]};
  assign time_o = {h7_q, mi7_q, s7_q};

endmodule

[hdl/dtpu_unpack_lane.sv]
module dtpu_unpack_lane import dtpu_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] date_i,
  input  logic [15:0] time_i,
  output logic        ok_o,
  output logic [32:0] epoch_o
);

  localparam int unsigned Tail = LaneDepth - 4;

  logic [6:0]  yr;
  logic [3:0]  mon, mp;
  logic [4:0]  day, hh, s2, dim;
  logic [5:0]  mi;
  logic        ok1_d;
  logic        ok1_q, ok2_q, ok3_q, ok4_q;
  logic [7:0]  yp1_q;
  logic [8:0]  base1_q;
  logic [4:0]  day1_q, hh1_q, s21_q;
  logic [5:0]  mi1_q;
  logic [8:0]  doy;
  logic [15:0] a2_q, a3_days;
  logic [16:0] tod2_q, tod3_q;
  logic [15:0] days3_q;
  logic [32:0] ep4_q;
  logic        ok_t_q [Tail];
  logic [32:0] ep_t_q [Tail];

  always_comb begin
    yr = date_i[15:9];
    mon = date_i[8:5];
    day = date_i[4:0];
    hh = time_i[15:11];
    mi = time_i[10:5];
    s2 = time_i[4:0];
    dim = month_len(mon);
    if (mon == 4'd2 && yr[1:0] == 2'd0 && yr != 7'd120) begin
      dim = 5'd29;
    end
    ok1_d = (mon >= 4'd1) && (mon <= 4'd12) && (day >= 5'd1) && (day <= dim) &&
            (hh <= 5'd23) && (mi <= 6'd59) && (s2 <= 5'd29);
    mp = (mon > 4'd2) ? mon - 4'd3 : mon + 4'd9;
  end

  assign doy = base1_q + 9'(day1_q) - 9'd1;
  assign a3_days = a2_q + MarchBase - 16'(a2_q >= Idx2100Mar);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok1_q <= ok1_d;
      yp1_q <= 8'(yr) + 8'd4 - 8'(mon <= 4'd2);
      base1_q <= month_base(mp);
      day1_q <= day;
      hh1_q <= hh;
      mi1_q <= mi;
      s21_q <= s2;
      ok2_q <= ok1_q;
      a2_q <= 16'(yp1_q) * 16'd365 + 16'(yp1_q[7:2]) + 16'(doy);
      tod2_q <= 17'(hh1_q) * 17'(SecsPerHour) + 17'(mi1_q) * 17'(SecsPerMin) +
                17'({s21_q, 1'b0});
      ok3_q <= ok2_q;
      days3_q <= a3_days;
      tod3_q <= tod2_q;
      ok4_q <= ok3_q;
      ep4_q <= 33'(days3_q) * 33'(SecsPerDay) + 33'(tod3_q);
      ok_t_q[0] <= ok4_q;
      ep_t_q[0] <= ep4_q;
      for (int i = 1; i < Tail; i++) begin
        ok_t_q[i] <= ok_t_q[i-1];
        ep_t_q[i] <= ep_t_q[i-1];
      end
    end
  end

  assign ok_o = ok_t_q[Tail-1];
  assign epoch_o = ep_t_q[Tail-1];

endmodule

[hdl/dos_timestamp_pack_unpack_core.sv]
// Converts Unix seconds to DOS date/time words (action 0) and DOS words back to
// Unix seconds (action 1). Pack clamps to 1980-01-01 00:00:00 .. 2107-12-31
// 23:59:58 and always reports ok; unpack reports ok low with all-zero fields for
// an invalid date or time. One request is taken per clock unless out_o stalls;
// pipeline depth is set by the chain of constant-reciprocal multiplies in the
// pack path. The whole pipeline holds while a result waits on out_o.
module dos_timestamp_pack_unpack_core import dtpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtpu_in_if.sink    in_i,
  dtpu_out_if.source out_o
);

  logic                 en;
  logic [LaneDepth-1:0] vld_q;
  logic [LaneDepth-1:0] act_q;
  logic [15:0]          p_date, p_time;
  logic                 u_ok;
  logic [32:0]          u_epoch;
  logic                 out_v_q, ok_q;
  logic [15:0]          date_q, time_q;
  logic [32:0]          epoch_q;

  assign en = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  dtpu_pack_lane u_pack (
    .clk_i   (clk_i),
    .en_i    (en),
    .epoch_i (in_i.epoch_seconds),
    .date_o  (p_date),
    .time_o  (p_time)
  );

  dtpu_unpack_lane u_unpack (
    .clk_i   (clk_i),
    .en_i    (en),
    .date_i  (in_i.packed_date),
    .time_i  (in_i.packed_time),
    .ok_o    (u_ok),
    .epoch_o (u_epoch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[LaneDepth-2:0], in_i.valid};
      out_v_q <= vld_q[LaneDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act_q <= {act_q[LaneDepth-2:0], in_i.action};
      if (act_q[LaneDepth-1]) begin
        ok_q <= u_ok;
        date_q <= '0;
        time_q <= '0;
        epoch_q <= u_ok ? u_epoch : '0;
      end else begin
        ok_q <= 1'b1;
        date_q <= p_date;
        time_q <= p_time;
        epoch_q <= '0;
      end
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.ok = ok_q;
  assign out_o.packed_date_out = date_q;
  assign out_o.packed_time_out = time_q;
  assign out_o.epoch_seconds_out = epoch_q;

endmodule

[hdl/dtpu_chk.sv]
module dtpu_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        ok_i,
  input logic [15:0] date_i,
  input logic [15:0] time_i,
  input logic [32:0] epoch_i
);

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> date_i == 16'd0 && time_i == 16'd0 && epoch_i == 33'd0)
    else $error("failed request carries data");

  a_pack_no_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && date_i != 16'd0 |-> ok_i && epoch_i == 33'd0)
    else $error("pack result carries seconds");

  a_unpack_no_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && epoch_i != 33'd0 |-> date_i == 16'd0 && time_i == 16'd0)
    else $error("unpack result carries words");

  a_pack_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && date_i != 16'd0 |-> date_i[8:5] >= 4'd1 && date_i[8:5] <= 4'd12 &&
    date_i[4:0] != 5'd0)
    else $error("packed date out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(epoch_i) && $stable(date_i))
    else $error("stalled result dropped");

endmodule

bind dos_timestamp_pack_unpack_core dtpu_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .ok_i        (out_o.ok),
  .date_i      (out_o.packed_date_out),
  .time_i      (out_o.packed_time_out),
  .epoch_i     (out_o.epoch_seconds_out)
);
